[hw/rtl/css_pkg.sv]
// Shared constants, register map and arrow template for the cursor sprite scaler.
`timescale 1ns / 1ps

package css_pkg;

  localparam int TEMPLATE_SIZE = 16;
  localparam int TPL_BITS      = $clog2(TEMPLATE_SIZE);

  localparam int MIN_CURSOR_SIZE_DEF     = 16;
  localparam int MAX_CURSOR_SIZE_DEF     = 64;
  localparam int DEFAULT_CURSOR_SIZE_DEF = 16;

  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;
  localparam int ARGB_W   = 32;

  localparam logic [ARGB_W-1:0] COLOR_BLACK = 32'hFF00_0000;
  localparam logic [ARGB_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [ARGB_W-1:0] COLOR_CLEAR = 32'h0000_0000;

  localparam logic [COORD_W-1:0] CURSOR_X_RST    = 12'd0;
  localparam logic [COORD_W-1:0] CURSOR_Y_RST    = 12'd0;
  localparam logic [SIZE_W-1:0]  CURSOR_W_RST    = 8'd16;
  localparam logic [SIZE_W-1:0]  CURSOR_H_RST    = 8'd16;
  localparam logic [COORD_W-1:0] CLIP_LEFT_RST   = 12'd0;
  localparam logic [COORD_W-1:0] CLIP_TOP_RST    = 12'd0;
  localparam logic [COORD_W-1:0] CLIP_RIGHT_RST  = 12'd1023;
  localparam logic [COORD_W-1:0] CLIP_BOTTOM_RST = 12'd767;

  typedef enum logic [2:0] {
    REG_CURSOR_X      = 3'd0,
    REG_CURSOR_Y      = 3'd1,
    REG_CURSOR_WIDTH  = 3'd2,
    REG_CURSOR_HEIGHT = 3'd3,
    REG_CLIP_LEFT     = 3'd4,
    REG_CLIP_TOP      = 3'd5,
    REG_CLIP_RIGHT    = 3'd6,
    REG_CLIP_BOTTOM   = 3'd7
  } reg_idx_t;

  typedef logic [TEMPLATE_SIZE-1:0] tpl_row_t;

  // bit n of a row is template column n
  localparam tpl_row_t BLACK_MASK [TEMPLATE_SIZE] = '{
    16'h0003, 16'h0005, 16'h0009, 16'h0015,
    16'h002D, 16'h005D, 16'h00BD, 16'h017D,
    16'h02FD, 16'h043D, 16'h03C5, 16'h0089,
    16'h0095, 16'h0113, 16'h0121, 16'h00E0
  };

  localparam tpl_row_t WHITE_MASK [TEMPLATE_SIZE] = '{
    16'h0000, 16'h0002, 16'h0006, 16'h000A,
    16'h0012, 16'h0022, 16'h0042, 16'h0082,
    16'h0102, 16'h03C2, 16'h003A, 16'h0076,
    16'h0062, 16'h00E0, 16'h00C0, 16'h0000
  };

endpackage

[hw/rtl/cursor_sprite_scaler.sv]
// Cursor overlay pixel generator: clamps, hit test, scaled template lookup.
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: pixel_x, pixel_y
// m_*       out  m_tvalid / m_tready    m_tdata: argb, m_tuser: hit
// apb       in   psel/penable/pwrite    8 registers at byte address 4*i
//
// One pixel per clock while m_tready does not stall; each accepted beat passes v1, v2, v3 and v4 before m_tvalid.
// Two bits of each 4-bit scale quotient are resolved per stage in the divider.
// rst is synchronous and clears the configuration registers and all stage valid bits.
// A stall on m_tready holds every stage; s_tready drops in the same cycle.
`timescale 1ns / 1ps

module cursor_sprite_scaler #(
  parameter int MIN_CURSOR_SIZE     = css_pkg::MIN_CURSOR_SIZE_DEF,
  parameter int MAX_CURSOR_SIZE     = css_pkg::MAX_CURSOR_SIZE_DEF,
  parameter int DEFAULT_CURSOR_SIZE = css_pkg::DEFAULT_CURSOR_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [css_pkg::APB_AW-1:0]    paddr,
  input  logic [css_pkg::APB_DW-1:0]    pwdata,
  output logic [css_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*css_pkg::COORD_W-1:0] s_tdata,   // pixel_x, pixel_y
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [css_pkg::ARGB_W-1:0]    m_tdata,   // argb
  output logic                          m_tuser    // hit
);
  import css_pkg::*;

  localparam int SZ_W = $clog2(MAX_CURSOR_SIZE + 1);
  localparam int HALF = TPL_BITS / 2;

  logic [COORD_W-1:0] cursor_x, cursor_y, clip_left, clip_top, clip_right, clip_bottom;
  logic [SIZE_W-1:0]  cursor_width, cursor_height;

  logic [SZ_W-1:0]    w_fix, h_fix, w_fix_next, h_fix_next;
  logic [COORD_W-1:0] cx_fix, cy_fix, cx_fix_next, cy_fix_next;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic               advance;
  logic               v1, v2, v3, v4;
  logic [COORD_W-1:0] s1_px, s1_py;
  logic               s2_in;
  logic [SZ_W-1:0]    s2_dx, s2_dy;
  logic               s3_in;
  logic [SZ_W-1:0]    s3_rx, s3_ry;
  logic [HALF-1:0]    s3_qx, s3_qy;
  logic               s4_in;
  logic [TPL_BITS-1:0] s4_qx, s4_qy;

  logic               in_clip, in_cursor;
  logic [COORD_W-1:0] dx_full, dy_full;
  logic [SZ_W-1:0]    s3_rx_next, s3_ry_next, s4_rx_unused, s4_ry_unused;
  logic [HALF-1:0]    s3_qx_next, s3_qy_next, s4_qx_lo, s4_qy_lo;
  logic               tpl_black, tpl_white;

  function automatic logic [SZ_W-1:0] size_fix(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] t;
    t = v;
    if (t == '0) t = SIZE_W'(DEFAULT_CURSOR_SIZE);
    if (t < SIZE_W'(MIN_CURSOR_SIZE)) t = SIZE_W'(MIN_CURSOR_SIZE);
    if (t > SIZE_W'(MAX_CURSOR_SIZE)) t = SIZE_W'(MAX_CURSOR_SIZE);
    return t[SZ_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] pos_fix(input logic [COORD_W-1:0] v,
                                                 input logic [COORD_W-1:0] lo,
                                                 input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] t;
    t = v;
    if (v < lo) t = lo;
    else if (v > hi) t = hi;
    return t;
  endfunction

  // restoring steps of rem*2^HALF / d, rem < d
  function automatic logic [HALF+SZ_W-1:0] div_half(input logic [SZ_W-1:0] rem,
                                                    input logic [SZ_W-1:0] d);
    logic [SZ_W-1:0] r;
    logic [SZ_W:0]   t;
    logic [HALF-1:0] q;
    r = rem;
    q = '0;
    for (int i = 0; i < HALF; i++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        q = {q[HALF-2:0], 1'b1};
      end else begin
        q = {q[HALF-2:0], 1'b0};
      end
      r = t[SZ_W-1:0];
    end
    return {q, r};
  endfunction

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= CURSOR_X_RST;
      cursor_y      <= CURSOR_Y_RST;
      cursor_width  <= CURSOR_W_RST;
      cursor_height <= CURSOR_H_RST;
      clip_left     <= CLIP_LEFT_RST;
      clip_top      <= CLIP_TOP_RST;
      clip_right    <= CLIP_RIGHT_RST;
      clip_bottom   <= CLIP_BOTTOM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CURSOR_X:      cursor_x      <= pwdata[COORD_W-1:0];
        REG_CURSOR_Y:      cursor_y      <= pwdata[COORD_W-1:0];
        REG_CURSOR_WIDTH:  cursor_width  <= pwdata[SIZE_W-1:0];
        REG_CURSOR_HEIGHT: cursor_height <= pwdata[SIZE_W-1:0];
        REG_CLIP_LEFT:     clip_left     <= pwdata[COORD_W-1:0];
        REG_CLIP_TOP:      clip_top      <= pwdata[COORD_W-1:0];
        REG_CLIP_RIGHT:    clip_right    <= pwdata[COORD_W-1:0];
        REG_CLIP_BOTTOM:   clip_bottom   <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CURSOR_X:      prdata = APB_DW'(cursor_x);
      REG_CURSOR_Y:      prdata = APB_DW'(cursor_y);
      REG_CURSOR_WIDTH:  prdata = APB_DW'(cursor_width);
      REG_CURSOR_HEIGHT: prdata = APB_DW'(cursor_height);
      REG_CLIP_LEFT:     prdata = APB_DW'(clip_left);
      REG_CLIP_TOP:      prdata = APB_DW'(clip_top);
      REG_CLIP_RIGHT:    prdata = APB_DW'(clip_right);
      REG_CLIP_BOTTOM:   prdata = APB_DW'(clip_bottom);
      default:           prdata = '0;
    endcase
  end

  // clamped geometry, registered, so it settles in the cycle after a register write
  assign w_fix_next  = size_fix(cursor_width);
  assign h_fix_next  = size_fix(cursor_height);
  assign cx_fix_next = pos_fix(cursor_x, clip_left, clip_right);
  assign cy_fix_next = pos_fix(cursor_y, clip_top, clip_bottom);

  always_ff @(posedge clk) begin
    w_fix  <= w_fix_next;
    h_fix  <= h_fix_next;
    cx_fix <= cx_fix_next;
    cy_fix <= cy_fix_next;
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_comb begin
    in_clip   = s1_px >= clip_left && s1_px <= clip_right &&
                s1_py >= clip_top  && s1_py <= clip_bottom;
    dx_full   = s1_px - cx_fix;
    dy_full   = s1_py - cy_fix;
    in_cursor = s1_px >= cx_fix && dx_full < COORD_W'(w_fix) &&
                s1_py >= cy_fix && dy_full < COORD_W'(h_fix);
    {s3_qx_next, s3_rx_next} = div_half(s2_dx, w_fix);
    {s3_qy_next, s3_ry_next} = div_half(s2_dy, h_fix);
    {s4_qx_lo, s4_rx_unused} = div_half(s3_rx, w_fix);
    {s4_qy_lo, s4_ry_unused} = div_half(s3_ry, h_fix);
    tpl_black = BLACK_MASK[s4_qy][s4_qx];
    tpl_white = WHITE_MASK[s4_qy][s4_qx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px <= s_tdata[COORD_W-1:0];
      s1_py <= s_tdata[2*COORD_W-1:COORD_W];
      s2_in <= in_clip && in_cursor;
      s2_dx <= dx_full[SZ_W-1:0];
      s2_dy <= dy_full[SZ_W-1:0];
      s3_in <= s2_in;
      s3_rx <= s3_rx_next;
      s3_ry <= s3_ry_next;
      s3_qx <= s3_qx_next;
      s3_qy <= s3_qy_next;
      s4_in <= s3_in;
      s4_qx <= {s3_qx, s4_qx_lo};
      s4_qy <= {s3_qy, s4_qy_lo};
      m_tuser <= s4_in && (tpl_black || tpl_white);
      if (s4_in && tpl_black)      m_tdata <= COLOR_BLACK;
      else if (s4_in && tpl_white) m_tdata <= COLOR_WHITE;
      else                         m_tdata <= COLOR_CLEAR;
    end
  end

  a_hit_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == COLOR_BLACK || m_tdata == COLOR_WHITE))
    else $error("hit beat without opaque color");

  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == COLOR_CLEAR)
    else $error("miss beat with nonzero color");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v3 && s3_in |-> (s3_rx < w_fix && s3_ry < h_fix))
    else $error("scale remainder out of range");

endmodule
